// ===== rtl/bmsa_pkg.sv =====
`timescale 1ns / 1ps
package bmsa_pkg;

	localparam int BIN_W    = 6;
	localparam int DATA_W   = 32;
	localparam int CFG_W    = 16;
	localparam int SUM_W    = 48;
	localparam int SQ_W     = 64;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_NORM = 1'b1;

	localparam logic REG_SAMPLE_COUNT = 1'b0;
	localparam logic REG_VAR_TOL      = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_N_RD,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_DIV2_GO,
		ST_DIV2_WAIT,
		ST_MUL,
		ST_VAR,
		ST_ROOT_WAIT,
		ST_LOAD
	} bmsa_state_t;

	typedef struct packed {
		logic in_ready;
		logic norm;      // read address follows the bin counter
		logic add_wr;
		logic idx_clr;
		logic div1_go;
		logic div2_go;
		logic mul;
		logic var_eval;
		logic load;
	} bmsa_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_norm;
		logic div_busy;
		logic root_busy;
		logic need_root;
		logic out_free;
		logic is_last;
	} bmsa_stat_t;

endpackage

// ===== rtl/bmsa_if.sv =====
`timescale 1ns / 1ps
interface bmsa_sample_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [5:0]  bin;
	logic signed [31:0] sample;
	logic [31:0] sample_sq;
	modport source (output valid, opcode, bin, sample, sample_sq, input ready);
	modport sink   (input valid, opcode, bin, sample, sample_sq, output ready);
endinterface

interface bmsa_result_if;
	logic        valid;
	logic        ready;
	logic [5:0]  out_bin;
	logic signed [31:0] mean;
	logic signed [31:0] spread;
	logic        variance_error;
	logic        last;
	modport source (output valid, out_bin, mean, spread, variance_error, last, input ready);
	modport sink   (input valid, out_bin, mean, spread, variance_error, last, output ready);
endinterface

interface bmsa_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/binned_mean_stddev_accumulator.sv =====
`timescale 1ns / 1ps
// Per-bin mean and standard deviation, Q16.16.
// Channels: samples (sink) takes add and normalize items; results (source)
// gives one transfer per bin on normalize; cfg (sink, always ready) writes
// sample_count (index 0) and variance_tolerance (index 1); the user must
// write them only while idle, which the block does not enforce. An add
// item is a registered read of the bin, then the write. A normalize item
// walks every bin in order, per bin: a read state, the shared bit-serial
// divider twice (start and wait states each; mean, then mean square), a
// multiply state, a variance state, the bit-serial square root (skipped
// when it is not needed) and a load state. A run also waits on any
// receiver stall. The last result of the run carries last = 1.
// Results sit in an output register; while the receiver stalls the next bin
// is still computed and the walk waits only to load it. Add items are taken
// while a final result is still pending.
// Reset: asynchronous, active low; all bins read as zero (a valid bit per
// bin, cleared at reset and as each bin is read by normalize), no clearing
// pass is needed. sample_count resets to 1, tolerance to 0.
module binned_mean_stddev_accumulator #(
	parameter int BINS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	bmsa_sample_if.sink   samples,
	bmsa_result_if.source results,
	bmsa_cfg_if.sink      cfg
);
	import bmsa_pkg::*;

	bmsa_cmd_t  cmd;
	bmsa_stat_t stat;

	// sequencing only
	bmsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// memories, divider, root, output register
	bmsa_datapath #(.BINS(BINS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg),
		.cmd     (cmd),
		.stat    (stat)
	);
endmodule

// ===== rtl/bmsa_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, 64-bit quotient, one quotient bit per cycle.
module bmsa_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [63:0] quotient
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dsr_q;
	logic [16:0] trial;
	logic        qbit;
	logic [16:0] diff;

	always_comb begin
		trial = {rem_q, quo_q[63]};
		qbit  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd63;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) busy_q <= 1'b0;
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], qbit};
			rem_q <= qbit ? diff[15:0] : trial[15:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/bmsa_isqrt.sv =====
`timescale 1ns / 1ps
// Digit-by-digit integer square root, 32-bit root, one root bit per cycle.
module bmsa_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] x_q;
	logic [31:0] root_q;
	logic [34:0] rem_q;
	logic [34:0] r;
	logic [34:0] trial;
	logic        take;

	always_comb begin
		r     = {rem_q[32:0], x_q[63:62]};
		trial = {1'b0, root_q, 2'b01};
		take  = r >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			if (cnt_q == 5'd0) busy_q <= 1'b0;
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[61:0], 2'b00};
			root_q <= {root_q[30:0], take};
			rem_q  <= take ? (r - trial) : r;
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

// ===== rtl/bmsa_datapath.sv =====
`timescale 1ns / 1ps
module bmsa_datapath #(
	parameter int BINS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	bmsa_sample_if.sink       samples,
	bmsa_result_if.source     results,
	bmsa_cfg_if.sink          cfg,
	input  bmsa_pkg::bmsa_cmd_t  cmd,
	output bmsa_pkg::bmsa_stat_t stat
);
	import bmsa_pkg::*;

	localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;

	// config
	logic [CFG_W-1:0] count_q;
	logic [CFG_W-1:0] tol_q;
	logic [CFG_W-1:0] div_eff;

	// bin memories, valid bit per bin stands in for the clear
	logic [SUM_W-1:0] sum_mem [BINS];
	logic [SQ_W-1:0]  sq_mem  [BINS];
	logic [BINS-1:0]  vld_q;
	logic [SUM_W-1:0] rd_sum_q;
	logic [SQ_W-1:0]  rd_sq_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] rd_addr;
	logic             in_range;

	// latched add item
	logic             add_ok_q;
	logic [IDX_W-1:0] add_addr_q;
	logic [DATA_W-1:0] add_s_q;
	logic [DATA_W-1:0] add_sq_q;

	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] cur_sum;
	logic [SQ_W-1:0]  cur_sq;
	logic [SUM_W-1:0] mag;
	logic             neg_q;
	logic [SQ_W-1:0]  sq_hold_q;

	logic             div_go;
	logic [SQ_W-1:0]  div_dividend;
	logic             div_busy;
	logic [SQ_W-1:0]  quo;

	logic [DATA_W-1:0] mean_q;
	logic [DATA_W-1:0] amean_q;
	logic [SQ_W-1:0]   msq_q;
	logic [SQ_W-1:0]   prod_s1;

	logic [SQ_W-1:0]   m2;
	logic [SQ_W-1:0]   vdiff;
	logic [SQ_W-1:0]   ndiff;
	logic              need_root_q;
	logic [DATA_W-1:0] spread_q;
	logic              err_q;
	logic              root_busy;
	logic [DATA_W-1:0] root;

	logic              out_valid_q;
	logic [BIN_W-1:0]  out_bin_q;
	logic [DATA_W-1:0] out_mean_q;
	logic [DATA_W-1:0] out_spread_q;
	logic              out_err_q;
	logic              out_last_q;
	logic              is_last;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd1;
			tol_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SAMPLE_COUNT: count_q <= cfg.data;
				REG_VAR_TOL:      tol_q   <= cfg.data;
				default:          ;
			endcase
		end
	end

	assign div_eff = (count_q == '0) ? 16'd1 : count_q;

	assign in_range = int'(samples.bin) < BINS;
	assign rd_addr  = cmd.norm ? idx_q : (in_range ? IDX_W'(samples.bin) : '0);
	assign is_last  = int'(idx_q) == BINS - 1;

	always_ff @(posedge clk) begin
		rd_sum_q <= sum_mem[rd_addr];
		rd_sq_q  <= sq_mem[rd_addr];
		if (cmd.add_wr && add_ok_q) begin
			sum_mem[add_addr_q] <= cur_sum + {{(SUM_W-DATA_W){add_s_q[DATA_W-1]}}, add_s_q};
			sq_mem[add_addr_q]  <= cur_sq + {{(SQ_W-DATA_W){1'b0}}, add_sq_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (cmd.add_wr && add_ok_q) vld_q[add_addr_q] <= 1'b1;
			else if (cmd.div1_go)       vld_q[idx_q]      <= 1'b0;
		end
	end

	assign cur_sum = rd_vld_q ? rd_sum_q : '0;
	assign cur_sq  = rd_vld_q ? rd_sq_q  : '0;
	assign mag     = cur_sum[SUM_W-1] ? (~cur_sum + 48'd1) : cur_sum;

	always_ff @(posedge clk) begin
		if (samples.valid && cmd.in_ready) begin
			add_ok_q   <= in_range;
			add_addr_q <= rd_addr;
			add_s_q    <= samples.sample;
			add_sq_q   <= samples.sample_sq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          idx_q <= '0;
		else if (cmd.idx_clr) idx_q <= '0;
		else if (cmd.load)    idx_q <= idx_q + IDX_W'(1);
	end

	// mean, then mean square, through the one divider
	assign div_go       = cmd.div1_go | cmd.div2_go;
	assign div_dividend = cmd.div1_go ? {{(SQ_W-SUM_W){1'b0}}, mag} : sq_hold_q;

	bmsa_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_eff),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.div1_go) begin
			neg_q     <= cur_sum[SUM_W-1];
			sq_hold_q <= cur_sq;
		end
		if (cmd.div2_go) begin
			if (neg_q) begin
				amean_q <= (quo > 64'h8000_0000) ? 32'h8000_0000 : quo[31:0];
				mean_q  <= (quo > 64'h8000_0000) ? 32'h8000_0000 : (~quo[31:0] + 32'd1);
			end else begin
				amean_q <= (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
				mean_q  <= (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
			end
		end
		if (cmd.mul) begin
			prod_s1 <= {32'd0, amean_q} * {32'd0, amean_q};
			msq_q   <= quo;
		end
	end

	assign m2    = {16'd0, prod_s1[63:16]};
	assign vdiff = msq_q - m2;
	assign ndiff = m2 - msq_q;

	always_ff @(posedge clk) begin
		if (cmd.var_eval) begin
			need_root_q <= 1'b0;
			err_q       <= 1'b0;
			if (msq_q >= m2) begin
				spread_q    <= 32'h7FFF_FFFF;
				need_root_q <= vdiff[63:46] == '0;
			end else if (ndiff > {48'd0, tol_q}) begin
				err_q    <= 1'b1;
				spread_q <= (ndiff > 64'h8000_0000) ? 32'h8000_0000 : (~ndiff[31:0] + 32'd1);
			end else begin
				spread_q <= '0;
			end
		end
	end

	bmsa_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.var_eval && (msq_q >= m2) && (vdiff[63:46] == '0)),
		.radicand ({vdiff[45:0], 18'd0} >> 2),
		.busy     (root_busy),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                          out_valid_q <= 1'b0;
		else if (cmd.load)                    out_valid_q <= 1'b1;
		else if (results.ready)               out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_bin_q    <= BIN_W'(idx_q);
			out_mean_q   <= mean_q;
			out_spread_q <= need_root_q ? root : spread_q;
			out_err_q    <= err_q;
			out_last_q   <= is_last;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.out_bin        = out_bin_q;
	assign results.mean           = out_mean_q;
	assign results.spread         = out_spread_q;
	assign results.variance_error = out_err_q;
	assign results.last           = out_last_q;
	assign samples.ready          = cmd.in_ready;

	always_comb begin
		stat.in_valid  = samples.valid;
		stat.in_norm   = samples.opcode == OP_NORM;
		stat.div_busy  = div_busy;
		stat.root_busy = root_busy;
		stat.need_root = need_root_q;
		stat.out_free  = !out_valid_q || results.ready;
		stat.is_last   = is_last;
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || results.ready))
		else $error("result register overwritten");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !div_busy)
		else $error("divider started while busy");
	a_err_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> out_spread_q[31])
		else $error("flagged variance not negative");
	a_vld_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div1_go |=> !vld_q[$past(idx_q)])
		else $error("bin not cleared after read");
endmodule

// ===== rtl/bmsa_ctrl.sv =====
`timescale 1ns / 1ps
module bmsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmsa_pkg::bmsa_stat_t stat,
	output bmsa_pkg::bmsa_cmd_t  cmd
);
	import bmsa_pkg::*;

	bmsa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.norm = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					if (stat.in_norm) begin
						cmd.idx_clr = 1'b1;
						state_d     = ST_N_RD;
					end else begin
						state_d = ST_ADD_WR;
					end
				end
			end
			ST_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_N_RD:      state_d = ST_DIV1_GO;
			ST_DIV1_GO: begin
				cmd.div1_go = 1'b1;
				state_d     = ST_DIV1_WAIT;
			end
			ST_DIV1_WAIT: if (!stat.div_busy) state_d = ST_DIV2_GO;
			ST_DIV2_GO: begin
				cmd.div2_go = 1'b1;
				state_d     = ST_DIV2_WAIT;
			end
			ST_DIV2_WAIT: if (!stat.div_busy) state_d = ST_MUL;
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_VAR;
			end
			ST_VAR: begin
				cmd.var_eval = 1'b1;
				state_d      = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: if (!stat.need_root || !stat.root_busy) state_d = ST_LOAD;
			ST_LOAD: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_d  = stat.is_last ? ST_IDLE : ST_N_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_ready |-> (state_q == ST_IDLE))
		else $error("ready outside idle");
	a_norm_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && stat.in_valid && stat.in_norm) |=> (state_q == ST_N_RD))
		else $error("normalize did not start");
	a_load_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && stat.is_last) |=> (state_q == ST_IDLE))
		else $error("walk did not end on last bin");
endmodule

// ===== verif/tb_binned_mean_stddev_accumulator.sv =====
`timescale 1ns / 1ps
module tb_binned_mean_stddev_accumulator;
	import bmsa_pkg::*;

	localparam int NBINS = 64;

	typedef struct {
		logic              op;
		logic [5:0]        bin;
		logic signed [31:0] sample;
		logic [31:0]       sample_sq;
	} stat_item_t;

	typedef struct {
		logic [5:0]  bin;
		logic [31:0] mean;
		logic [31:0] spread;
		logic        var_err;
		logic        last;
	} bin_stat_t;

	logic clk;
	logic arst_n;

	bmsa_sample_if samples();
	bmsa_result_if results();
	bmsa_cfg_if    cfg();

	binned_mean_stddev_accumulator #(.BINS(NBINS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.results(results),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Shadow of the accumulators and registers
	logic [47:0] acc_sum [NBINS];
	logic [63:0] acc_sq  [NBINS];
	logic [15:0] divisor_reg;
	logic [15:0] tol_reg;

	stat_item_t pending_items[$];
	bin_stat_t  expected_stats[$];
	int         errors;
	int         n_adds, n_norms, n_checked;

	// floor(sqrt(x)), digit-by-digit
	function automatic logic [63:0] root_floor(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Apply one accepted item to the shadow state; normalize queues 64 stats.
	task automatic accumulate_or_normalize(input stat_item_t it);
		logic [63:0] dv, mag, q, m2, msq, vr, nmag, spr;
		logic signed [47:0] s;
		logic        neg, err;
		logic [31:0] mb;
		bin_stat_t   r;
		dv = (divisor_reg == 0) ? 64'd1 : {48'd0, divisor_reg};
		if (it.op == OP_ADD) begin
			n_adds++;
			acc_sum[it.bin] = acc_sum[it.bin] + {{16{it.sample[31]}}, it.sample};
			acc_sq[it.bin]  = acc_sq[it.bin] + {32'd0, it.sample_sq};
		end else begin
			n_norms++;
			for (int i = 0; i < NBINS; i++) begin
				s   = acc_sum[i];
				neg = s < 0;
				mag = neg ? 64'(-s) : 64'(s);
				q   = mag / dv;
				if (neg) begin
					if (q > 64'h8000_0000) q = 64'h8000_0000;
					mb = 32'(-q);
				end else begin
					if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
					mb = q[31:0];
				end
				m2  = (q * q) >> 16;
				msq = acc_sq[i] / dv;
				err = 1'b0;
				if (msq >= m2) begin
					vr  = msq - m2;
					spr = (vr >= (64'd1 << 46)) ? 64'h7FFF_FFFF : root_floor(vr << 16);
				end else begin
					nmag = m2 - msq;
					if (nmag > {48'd0, tol_reg}) begin
						// flagged: raw negative variance, clipped at -2^31
						err = 1'b1;
						if (nmag > 64'h8000_0000) nmag = 64'h8000_0000;
						spr = -nmag;
					end else begin
						spr = 0;
					end
				end
				r.bin     = i[5:0];
				r.mean    = mb;
				r.spread  = spr[31:0];
				r.var_err = err;
				r.last    = (i == NBINS - 1);
				expected_stats.push_back(r);
				acc_sum[i] = 0;
				acc_sq[i]  = 0;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $time);
		errors++;
	endtask

	// Driver: bursts of random length, random gaps
	stat_item_t on_bus;
	int burst_left, gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples.valid     <= 1'b0;
			samples.opcode    <= OP_ADD;
			samples.bin       <= '0;
			samples.sample    <= '0;
			samples.sample_sq <= '0;
			burst_left = 4;
			gap_left   = 0;
		end else begin
			if (samples.valid && samples.ready) accumulate_or_normalize(on_bus);
			if (!samples.valid || samples.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					samples.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					on_bus = pending_items.pop_front();
					samples.valid     <= 1'b1;
					samples.opcode    <= on_bus.op;
					samples.bin       <= on_bus.bin;
					samples.sample    <= on_bus.sample;
					samples.sample_sq <= on_bus.sample_sq;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					samples.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: own stall pattern, plus one long hold-off on request
	int  stall_pct;
	bit  long_hold_req;
	bit  long_hold_done;
	int  hold_cnt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			hold_cnt = 0;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_done = 1;
			hold_cnt = 600;
			results.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		bin_stat_t e;
		if (arst_n && results.valid && results.ready) begin
			if (expected_stats.size() == 0) begin
				report_mismatch("unexpected transfer", {26'd0, results.out_bin}, 0);
			end else begin
				e = expected_stats.pop_front();
				n_checked++;
				if (results.out_bin !== e.bin)
					report_mismatch("out_bin", {26'd0, results.out_bin}, {26'd0, e.bin});
				if (results.mean !== e.mean) report_mismatch("mean", results.mean, e.mean);
				if (results.spread !== e.spread)
					report_mismatch("spread", results.spread, e.spread);
				if (results.variance_error !== e.var_err)
					report_mismatch("variance_error", {31'd0, results.variance_error},
						{31'd0, e.var_err});
				if (results.last !== e.last)
					report_mismatch("last", {31'd0, results.last}, {31'd0, e.last});
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_SAMPLE_COUNT) divisor_reg = val;
		else tol_reg = val;
		cfg.valid <= 1'b0;
	endtask

	task automatic queue_item(input logic op, input logic [5:0] b,
			input logic [31:0] s, input logic [31:0] sq);
		stat_item_t it;
		it.op = op;
		it.bin = b;
		it.sample = s;
		it.sample_sq = sq;
		pending_items.push_back(it);
	endtask

	// Sender pauses here until the block has drained; adds leave no result,
	// so keep waiting afterwards for the last read-modify-write.
	task automatic drain();
		while (pending_items.size() > 0 || samples.valid || expected_stats.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Random phase: mostly consistent sample/square pairs, some noise
	task automatic random_phase(input int count);
		logic [31:0] s, sq;
		logic signed [63:0] w;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 29) == 0) begin
				queue_item(OP_NORM, 6'($urandom), $urandom, $urandom);
			end else if ($urandom_range(0, 3) != 0) begin
				w  = $signed($urandom_range(0, 32'h00FF_FFFF)) - 64'sh0080_0000;
				s  = w[31:0];
				sq = 32'((w * w) >>> 16) + $urandom_range(0, 255);
				queue_item(OP_ADD, 6'($urandom_range(0, 7)), s, sq);
			end else begin
				queue_item(OP_ADD, 6'($urandom), $urandom, $urandom);
			end
		end
		queue_item(OP_NORM, 6'($urandom), $urandom, $urandom);
	endtask

	initial begin
		errors = 0; n_adds = 0; n_norms = 0; n_checked = 0;
		stall_pct = 30;
		long_hold_req = 0;
		long_hold_done = 0;
		cfg.valid = 1'b0;
		cfg.index = REG_SAMPLE_COUNT;
		cfg.data  = '0;
		divisor_reg = 16'd1;
		tol_reg     = 16'd0;
		for (int i = 0; i < NBINS; i++) begin
			acc_sum[i] = 0;
			acc_sq[i]  = 0;
		end
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, reset settings (count 1, tolerance 0)
		queue_item(OP_ADD, 6'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_item(OP_ADD, 6'd0, 32'h7FFF_FFFF, 32'h0000_0000); // mean saturates high
		queue_item(OP_ADD, 6'd1, 32'h8000_0000, 32'h0000_0000);
		queue_item(OP_ADD, 6'd1, 32'h8000_0000, 32'h0000_0001); // saturates low
		queue_item(OP_ADD, 6'd2, 32'h7FFF_FFFF, 32'h0000_0010); // flagged, clipped
		queue_item(OP_ADD, 6'd3, 32'h0001_0000, 32'h0000_FFFF); // tiny negative, flagged
		queue_item(OP_ADD, 6'd4, 32'h0000_0000, 32'hFFFF_FFFF); // big variance
		queue_item(OP_ADD, 6'd63, 32'hFFFF_0000, 32'h0001_0000);
		queue_item(OP_ADD, 6'd62, 32'h0002_0000, 32'h0004_0000); // exact zero variance
		queue_item(OP_NORM, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// Tolerance and divisor at the top, tolerance absorbs small negatives
		write_reg(REG_VAR_TOL, 16'hFFFF);
		write_reg(REG_SAMPLE_COUNT, 16'hFFFF);
		queue_item(OP_ADD, 6'd5, 32'h7FFF_FFFF, 32'h0000_0000);
		queue_item(OP_ADD, 6'd6, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_item(OP_ADD, 6'd7, 32'h5555_5555, 32'hAAAA_AAAA);
		queue_item(OP_NORM, 6'd0, 32'd0, 32'd0);
		drain();

		// Zero divisor acts as one; small tolerance
		write_reg(REG_SAMPLE_COUNT, 16'd0);
		write_reg(REG_VAR_TOL, 16'd100);
		queue_item(OP_ADD, 6'd8, 32'h0001_0000, 32'h0000_FFC0); // within tolerance
		queue_item(OP_ADD, 6'd9, 32'h0001_0000, 32'h0000_FF00); // beyond tolerance
		queue_item(OP_ADD, 6'd10, 32'hAAAA_AAAA, 32'h5555_5555);
		random_phase(50);
		drain();

		// Long receiver hold-off while items keep coming: a walk starts first,
		// stalls on the held results, and the adds behind it wait at the input
		write_reg(REG_SAMPLE_COUNT, 16'd3);
		write_reg(REG_VAR_TOL, 16'd0);
		stall_pct = 10;
		long_hold_req = 1;
		queue_item(OP_NORM, 6'd0, 32'd0, 32'd0);
		random_phase(60);
		drain();

		write_reg(REG_SAMPLE_COUNT, 16'd1);
		write_reg(REG_VAR_TOL, 16'd16);
		stall_pct = 0;
		random_phase(50);
		drain();

		write_reg(REG_SAMPLE_COUNT, 16'd17);
		stall_pct = 60;
		random_phase(50);
		drain();
		repeat (200) @(posedge clk);

		$display("run covered %0d add and %0d normalize transfers, %0d bin results checked",
			n_adds, n_norms, n_checked);
		$display("divisors 1, 65535, 0, 3, 17; tolerances 0 to 65535; long output stall");
		if (errors == 0 && expected_stats.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout");
		$display("FAILED: results differ");
		$finish;
	end

endmodule
